>>> design/sfla_pkg.sv
// Shared constants, command/status structs and the bucket index function
// for the segregated free-list allocator. No dependencies.
package sfla_pkg;

    localparam int NUM_BUCKETS_DEF  = 25;
    localparam int MAX_BLOCKS_DEF   = 1024;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int BUCKET_SHIFT_DEF = 10;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RESIZE  = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_INV = 2'd2;

    // Datapath command codes
    localparam logic [3:0] DP_NOP       = 4'd0;
    localparam logic [3:0] DP_LOAD      = 4'd1;
    localparam logic [3:0] DP_RD_H      = 4'd2;
    localparam logic [3:0] DP_WALK_INIT = 4'd3;
    localparam logic [3:0] DP_RD_CUR    = 4'd4;
    localparam logic [3:0] DP_STEP      = 4'd5;
    localparam logic [3:0] DP_UNLINK_A  = 4'd6;
    localparam logic [3:0] DP_UNLINK_B  = 4'd7;
    localparam logic [3:0] DP_CARVE     = 4'd8;
    localparam logic [3:0] DP_REL       = 4'd9;
    localparam logic [3:0] DP_RES_KEEP  = 4'd10;
    localparam logic [3:0] DP_RES_TOP   = 4'd11;
    localparam logic [3:0] DP_RES_OOM   = 4'd12;
    localparam logic [3:0] DP_RES_INV   = 4'd13;
    localparam logic [3:0] DP_PUSH      = 4'd14;

    typedef struct packed {
        logic [3:0] code;
        logic       latch_old;
    } sfla_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       h_zero;
        logic       h_valid;
        logic       size_zero;
        logic       hit;
        logic       walk_go;
        logic       full;
        logic       over;
        logic       out_busy;
    } sfla_sts_t;

    // Bit length of (size >> shift), clamped to the last bucket
    function automatic logic [5:0] bucket_of(input logic [31:0] size, input int shift,
                                             input int nb);
        logic [31:0] v;
        logic [5:0]  n;
        v = size >> shift;
        n = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
                n = 6'(i + 1);
        end
        if (n > 6'(nb - 1))
            n = 6'(nb - 1);
        return n;
    endfunction

endpackage

>>> design/sfla_dp.sv
// Datapath: block tables, bucket heads, heap top, walk registers and
// the result register. Depends on sfla_pkg.
module sfla_dp import sfla_pkg::*; #(
    parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int BUCKET_SHIFT = BUCKET_SHIFT_DEF,
    parameter int HW = $clog2(MAX_BLOCKS + 1),
    parameter int AW = $clog2(MAX_BLOCKS),
    parameter int BW = $clog2(NUM_BUCKETS)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sfla_cmd_t       cmd,
    input  logic [1:0]      in_op,
    input  logic [31:0]     in_size,
    input  logic [HW-1:0]   in_handle,
    input  logic            base_wr,
    input  logic [31:0]     heap_base,
    input  logic [31:0]     heap_limit,
    input  logic            out_ready,
    output sfla_sts_t       sts,
    output logic            out_valid,
    output logic [1:0]      status,
    output logic [HW-1:0]   result_handle,
    output logic [31:0]     payload_address,
    output logic [31:0]     granted_size
);

    logic [31:0]   size_mem [MAX_BLOCKS];
    logic [HW-1:0] next_mem [MAX_BLOCKS];
    logic [31:0]   base_mem [MAX_BLOCKS];
    logic [HW-1:0] head_reg [NUM_BUCKETS];

    logic [1:0]    op_reg;
    logic [31:0]   req_reg;
    logic [HW-1:0] h_reg;
    logic [31:0]   old_size_reg;
    logic [HW-1:0] prev_reg;
    logic [HW-1:0] cur_reg;
    logic [HW-1:0] steps_reg;
    logic [BW-1:0] bkt_reg;
    logic [HW-1:0] created_reg;
    logic [31:0]   top_reg;
    logic [31:0]   rd_size_reg;
    logic [HW-1:0] rd_next_reg;
    logic [31:0]   rd_base_reg;
    logic          ovalid_reg;
    logic [1:0]    st_reg;
    logic [HW-1:0] rh_reg;
    logic [31:0]   pa_reg;
    logic [31:0]   gs_reg;

    logic [BW-1:0] req_bkt;
    logic [BW-1:0] old_bkt;
    logic [BW-1:0] head_idx;
    logic [HW-1:0] head_rd;
    logic [HW-1:0] h_m1;
    logic [HW-1:0] cur_m1;
    logic [HW-1:0] prev_m1;
    logic [32:0]   new_top;

    assign req_bkt  = BW'(bucket_of(req_reg, BUCKET_SHIFT, NUM_BUCKETS));
    assign old_bkt  = BW'(bucket_of(old_size_reg, BUCKET_SHIFT, NUM_BUCKETS));
    assign head_idx = (cmd.code == DP_REL) ? old_bkt : req_bkt;
    assign head_rd  = head_reg[head_idx];
    assign h_m1     = h_reg - HW'(1);
    assign cur_m1   = cur_reg - HW'(1);
    assign prev_m1  = prev_reg - HW'(1);
    assign new_top  = {1'b0, top_reg} + {1'b0, req_reg} + 33'(HEADER_BYTES);

    always_comb
    begin
        sts.op        = op_reg;
        sts.h_zero    = (h_reg == '0);
        sts.h_valid   = (h_reg != '0) && (h_reg <= created_reg);
        sts.size_zero = (req_reg == '0);
        sts.hit       = (rd_size_reg >= req_reg);
        sts.walk_go   = (cur_reg != '0) && (cur_reg <= created_reg) &&
                        (steps_reg < created_reg);
        sts.full      = ({1'b0, created_reg} >= (HW + 1)'(MAX_BLOCKS));
        sts.over      = (new_top > {1'b0, heap_limit});
        sts.out_busy  = ovalid_reg;
    end

    // Tables: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd.code == DP_CARVE)
        begin
            size_mem[created_reg[AW-1:0]] <= req_reg;
            base_mem[created_reg[AW-1:0]] <= top_reg;
        end
        case (cmd.code)
            DP_UNLINK_A:
            begin
                if (prev_reg != '0)
                    next_mem[prev_m1[AW-1:0]] <= rd_next_reg;
            end
            DP_UNLINK_B: next_mem[cur_m1[AW-1:0]] <= '0;
            DP_CARVE:    next_mem[created_reg[AW-1:0]] <= '0;
            DP_REL:      next_mem[h_m1[AW-1:0]] <= head_rd;
            default:     ;
        endcase
        if (cmd.code == DP_RD_H)
        begin
            rd_size_reg <= size_mem[h_m1[AW-1:0]];
            rd_next_reg <= next_mem[h_m1[AW-1:0]];
            rd_base_reg <= base_mem[h_m1[AW-1:0]];
        end
        else if (cmd.code == DP_RD_CUR)
        begin
            rd_size_reg <= size_mem[cur_m1[AW-1:0]];
            rd_next_reg <= next_mem[cur_m1[AW-1:0]];
            rd_base_reg <= base_mem[cur_m1[AW-1:0]];
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_old)
            old_size_reg <= rd_size_reg;
        case (cmd.code)
            DP_LOAD:
            begin
                op_reg  <= in_op;
                req_reg <= in_size;
                h_reg   <= in_handle;
                st_reg  <= ST_OK;
                rh_reg  <= '0;
                pa_reg  <= '0;
                gs_reg  <= '0;
            end
            DP_WALK_INIT:
            begin
                bkt_reg   <= req_bkt;
                cur_reg   <= head_rd;
                prev_reg  <= '0;
                steps_reg <= '0;
            end
            DP_STEP:
            begin
                prev_reg  <= cur_reg;
                cur_reg   <= rd_next_reg;
                steps_reg <= steps_reg + HW'(1);
            end
            DP_UNLINK_B:
            begin
                rh_reg <= cur_reg;
                pa_reg <= rd_base_reg + 32'(HEADER_BYTES);
                gs_reg <= rd_size_reg;
            end
            DP_CARVE:
            begin
                rh_reg <= created_reg + HW'(1);
                pa_reg <= top_reg + 32'(HEADER_BYTES);
                gs_reg <= req_reg;
            end
            DP_RES_KEEP:
            begin
                rh_reg <= h_reg;
                pa_reg <= rd_base_reg + 32'(HEADER_BYTES);
                gs_reg <= rd_size_reg;
            end
            DP_RES_TOP: pa_reg <= top_reg;
            DP_RES_OOM: st_reg <= ST_OOM;
            DP_RES_INV: st_reg <= ST_INV;
            default:    ;
        endcase
    end

    // Control state: heads, heap top, block count, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
                head_reg[i] <= '0;
            created_reg <= '0;
            top_reg     <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (base_wr && (created_reg == '0))
                top_reg <= heap_base;
            case (cmd.code)
                DP_UNLINK_A:
                begin
                    if (prev_reg == '0)
                        head_reg[bkt_reg] <= rd_next_reg;
                end
                DP_REL: head_reg[old_bkt] <= h_reg;
                DP_CARVE:
                begin
                    created_reg <= created_reg + HW'(1);
                    top_reg     <= new_top[31:0];
                end
                default: ;
            endcase
            if (cmd.code == DP_PUSH)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    assign out_valid       = ovalid_reg;
    assign status          = st_reg;
    assign result_handle   = rh_reg;
    assign payload_address = pa_reg;
    assign granted_size    = gs_reg;

endmodule

>>> design/sfla_ctrl.sv
// Controller: sequences decode, list walk, carve and release steps.
// Depends on sfla_pkg.
module sfla_ctrl import sfla_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  sfla_sts_t sts,
    output logic      in_ready,
    output sfla_cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_RELCHK = 4'd2;
    localparam logic [3:0] S_RSCHK  = 4'd3;
    localparam logic [3:0] S_WTEST  = 4'd4;
    localparam logic [3:0] S_WCMP   = 4'd5;
    localparam logic [3:0] S_UNLB   = 4'd6;
    localparam logic [3:0] S_REL    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       resize_reg, resize_next;

    assign in_ready = (state_reg == S_IDLE) && !sts.out_busy;

    always_comb
    begin
        state_next    = state_reg;
        resize_next   = resize_reg;
        cmd.code      = DP_NOP;
        cmd.latch_old = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.code   = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                resize_next = 1'b0;
                if (sts.op == OP_ALLOC || (sts.op == OP_RESIZE && sts.h_zero))
                begin
                    if (sts.size_zero)
                    begin
                        cmd.code   = DP_RES_TOP;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.code   = DP_WALK_INIT;
                        state_next = S_WTEST;
                    end
                end
                else if (sts.op == OP_RELEASE || sts.op == OP_RESIZE)
                begin
                    if (sts.h_zero)
                        state_next = S_OUT;
                    else if (!sts.h_valid)
                    begin
                        cmd.code   = DP_RES_INV;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.code   = DP_RD_H;
                        state_next = (sts.op == OP_RELEASE) ? S_RELCHK : S_RSCHK;
                    end
                end
                else
                    state_next = S_OUT;
            end
            S_RELCHK:
            begin
                cmd.latch_old = 1'b1;
                state_next    = S_REL;
            end
            S_RSCHK:
            begin
                cmd.latch_old = 1'b1;
                if (sts.size_zero)
                    state_next = S_REL;
                else if (sts.hit)
                begin
                    cmd.code   = DP_RES_KEEP;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.code    = DP_WALK_INIT;
                    resize_next = 1'b1;
                    state_next  = S_WTEST;
                end
            end
            S_WTEST:
            begin
                if (sts.walk_go)
                begin
                    cmd.code   = DP_RD_CUR;
                    state_next = S_WCMP;
                end
                else if (sts.full || sts.over)
                begin
                    cmd.code   = DP_RES_OOM;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.code   = DP_CARVE;
                    state_next = resize_reg ? S_REL : S_OUT;
                end
            end
            S_WCMP:
            begin
                if (sts.hit)
                begin
                    cmd.code   = DP_UNLINK_A;
                    state_next = S_UNLB;
                end
                else
                begin
                    cmd.code   = DP_STEP;
                    state_next = S_WTEST;
                end
            end
            S_UNLB:
            begin
                cmd.code   = DP_UNLINK_B;
                state_next = resize_reg ? S_REL : S_OUT;
            end
            S_REL:
            begin
                cmd.code   = DP_REL;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.code   = DP_PUSH;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            resize_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            resize_reg <= resize_next;
        end
    end

endmodule

>>> design/segregated_free_list_allocator.sv
// Segregated free-list heap allocator with power-of-two size buckets.
// Channels: s_tdata requests (s_tvalid/s_tready), m_tdata results
// (m_tvalid/m_tready), one result beat per request beat. APB port holds
// heap_base (address 0) and heap_limit (address 4); write them only when idle.
// Each free-list entry visited by allocate takes one table read and one
// compare; a resize that moves the block adds a size check and the release
// of the old block. The walk through the bucket's free list, one entry per
// table read, sets the time per request; a new request is taken in the
// cycle after the result beat of the previous one leaves the output register.
// Reset: bucket lists empty, no blocks, heap top at heap_base (0), limit
// all ones. Block tables are not cleared; only created handles are read.
// When the receiver stalls the result beat holds in the output register and
// no new request is taken until it is accepted.
// Depends on sfla_pkg, sfla_ctrl, sfla_dp.
module segregated_free_list_allocator import sfla_pkg::*; #(
    parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int BUCKET_SHIFT = BUCKET_SHIFT_DEF,
    parameter int HW   = $clog2(MAX_BLOCKS + 1),
    parameter int IN_W  = ((2 + 32 + HW + 7) / 8) * 8,
    parameter int OUT_W = ((2 + HW + 64 + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    // op, request_size, block_handle (lowest bit first)
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // status, result_handle, payload_address, granted_size (lowest bit first)
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [2:0] ADDR_BASE  = 3'd0;
    localparam logic [2:0] ADDR_LIMIT = 3'd4;

    logic [31:0]   heap_base_reg;
    logic [31:0]   heap_limit_reg;
    logic          cfg_wr;
    logic          base_wr;
    sfla_cmd_t     cmd;
    sfla_sts_t     sts;
    logic [1:0]    status;
    logic [HW-1:0] result_handle;
    logic [31:0]   payload_address;
    logic [31:0]   granted_size;

    // Register file: write on the access phase
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign base_wr = cfg_wr && (paddr == ADDR_BASE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= '0;
            heap_limit_reg <= '1;
        end
        else if (cfg_wr)
        begin
            if (paddr == ADDR_BASE)
                heap_base_reg <= pwdata;
            else if (paddr == ADDR_LIMIT)
                heap_limit_reg <= pwdata;
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_BASE:  prdata = heap_base_reg;
            ADDR_LIMIT: prdata = heap_limit_reg;
            default:    prdata = '0;
        endcase
    end

    sfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .sts      (sts),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    sfla_dp #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .BUCKET_SHIFT (BUCKET_SHIFT),
        .HW           (HW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .in_op           (s_tdata[1:0]),
        .in_size         (s_tdata[33:2]),
        .in_handle       (s_tdata[HW+33:34]),
        .base_wr         (base_wr),
        .heap_base       (pwdata),
        .heap_limit      (heap_limit_reg),
        .out_ready       (m_tready),
        .sts             (sts),
        .out_valid       (m_tvalid),
        .status          (status),
        .result_handle   (result_handle),
        .payload_address (payload_address),
        .granted_size    (granted_size)
    );

    // Pack the result beat, zero padding on top
    assign m_tdata = OUT_W'({granted_size, payload_address, result_handle, status});

    // Never take a request while a result beat is still held
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !m_tvalid)
        else $error("request taken while result pending");

    // Only the three defined status codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("undefined status code");

    // A failed request grants no handle
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tdata[HW+1:2] == '0))
        else $error("handle granted with error status");

    // A new result beat only follows an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !s_tready)
        else $error("result without request");

endmodule

>>> tb/sfla_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the segregated free-list allocator: watches the request,
// result and APB channels, keeps its own heap model and compares each result.
// Depends on sfla_pkg for the op and status codes.
module sfla_checker import sfla_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [47:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    localparam int NBKT = 25;
    localparam int NBLK = 1024;
    localparam int HDR  = 16;

    // Highest field first, so status lands in the lowest bits as on m_tdata
    typedef struct packed {
        logic [31:0] gsize;
        logic [31:0] addr;
        logic [10:0] handle;
        logic [1:0]  status;
    } grant_t;

    grant_t      grants_due[$];
    logic [31:0] blk_size [1:NBLK];
    logic [10:0] blk_next [1:NBLK];
    logic [31:0] blk_base [1:NBLK];
    logic [10:0] free_head [0:NBKT-1];
    int          created;
    logic [31:0] heap_top;
    logic [31:0] heap_base;
    logic [31:0] heap_limit;

    assign pending = grants_due.size();

    function automatic int size_bucket(logic [31:0] sz);
        logic [31:0] v;
        int          n;
        v = sz >> 10;
        n = 0;
        while (v != 0)
        begin
            n++;
            v = v >> 1;
        end
        return (n > NBKT - 1) ? NBKT - 1 : n;
    endfunction

    function automatic bit live(logic [10:0] h);
        return h >= 1 && int'(h) <= created;
    endfunction

    function automatic void push_free(logic [10:0] h);
        int b;
        b = size_bucket(blk_size[h]);
        blk_next[h] = free_head[b];
        free_head[b] = h;
    endfunction

    // First-fit from the bucket list, else carve at the heap top
    function automatic logic [1:0] find_block(logic [31:0] sz, output logic [10:0] h);
        int          b;
        int          steps;
        logic [10:0] prev;
        logic [10:0] cur;
        logic [10:0] nxt;
        logic [63:0] new_top;
        b = size_bucket(sz);
        prev = 0;
        cur = free_head[b];
        steps = 0;
        h = 0;
        while (cur != 0 && live(cur) && steps < created)
        begin
            nxt = blk_next[cur];
            if (blk_size[cur] >= sz)
            begin
                if (prev == 0)
                    free_head[b] = nxt;
                else
                    blk_next[prev] = nxt;
                blk_next[cur] = 0;
                h = cur;
                return ST_OK;
            end
            prev = cur;
            cur = nxt;
            steps++;
        end
        if (created >= NBLK)
            return ST_OOM;
        new_top = 64'(heap_top) + 64'(sz) + HDR;
        if (new_top > 64'(heap_limit))
            return ST_OOM;
        created++;
        h = 11'(created);
        blk_size[h] = sz;
        blk_next[h] = 0;
        blk_base[h] = heap_top;
        heap_top = new_top[31:0];
        return ST_OK;
    endfunction

    function automatic grant_t granted(logic [10:0] h);
        grant_t g;
        g.status = ST_OK;
        g.handle = h;
        g.addr = blk_base[h] + HDR;
        g.gsize = blk_size[h];
        return g;
    endfunction

    function automatic grant_t serve_alloc(logic [31:0] sz);
        grant_t      g;
        logic [10:0] h;
        logic [1:0]  st;
        g = '0;
        if (sz == 0)
        begin
            g.addr = heap_top;
            return g;
        end
        st = find_block(sz, h);
        if (st != ST_OK)
        begin
            g.status = st;
            return g;
        end
        return granted(h);
    endfunction

    function automatic grant_t predict_grant(logic [1:0] op, logic [31:0] sz, logic [10:0] h);
        grant_t      g;
        logic [10:0] nh;
        logic [1:0]  st;
        g = '0;
        if (op == OP_ALLOC)
            g = serve_alloc(sz);
        else if (op == OP_RELEASE)
        begin
            if (h != 0 && !live(h))
                g.status = ST_INV;
            else if (h != 0)
                push_free(h);
        end
        else if (op == OP_RESIZE)
        begin
            if (h == 0)
                g = serve_alloc(sz);
            else if (!live(h))
                g.status = ST_INV;
            else if (sz == 0)
                push_free(h);
            else if (blk_size[h] >= sz)
                g = granted(h);
            else
            begin
                st = find_block(sz, nh);
                if (st != ST_OK)
                    g.status = st;
                else
                begin
                    push_free(h);
                    g = granted(nh);
                end
            end
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_t got;
        grant_t want;
        if (!rst_n)
        begin
            grants_due.delete();
            foreach (free_head[i])
                free_head[i] = 0;
            created = 0;
            heap_base = 0;
            heap_limit = 32'hFFFF_FFFF;
            heap_top = 0;
            fail_count = 0;
            checked = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == 3'd0)
                begin
                    heap_base = pwdata;
                    if (created == 0)
                        heap_top = pwdata;
                end
                else if (paddr == 3'd4)
                    heap_limit = pwdata;
            end
            // compare the outgoing beat before queueing the new one
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[76:0];
                checked++;
                if (grants_due.size() == 0)
                begin
                    $error("result beat with nothing outstanding: %h", got);
                    fail_count++;
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.handle !== want.handle)
                    begin
                        $error("result_handle: expected %0d, got %0d", want.handle, got.handle);
                        fail_count++;
                    end
                    if (got.addr !== want.addr)
                    begin
                        $error("payload_address: expected %h, got %h", want.addr, got.addr);
                        fail_count++;
                    end
                    if (got.gsize !== want.gsize)
                    begin
                        $error("granted_size: expected %h, got %h", want.gsize, got.gsize);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                grants_due.push_back(predict_grant(s_tdata[1:0], s_tdata[33:2], s_tdata[44:34]));
        end
    end

endmodule

>>> tb/tb_segregated_free_list_allocator.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the segregated free-list allocator: directed and
// random request beats across several heap settings. Depends on sfla_pkg, the
// design and sfla_checker.
module tb_segregated_free_list_allocator import sfla_pkg::*;;

    localparam int WATCHDOG_LIMIT = 40000;

    logic        clk;
    logic        rst_n;
    // op, request_size, block_handle, zero fill (lowest bit first)
    logic [47:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    // status, result_handle, payload_address, granted_size, zero fill
    logic [79:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          checked;
    bit          calm;          // suppress idling on both sides
    int          idle_cycles;
    int          op_count [4];
    logic [10:0] seen_handles [64];
    int          seen_wr;

    segregated_free_list_allocator uut (.*);

    sfla_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: drop ready with a chance of roughly 13 in a hundred unless calm
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 13);

    // Remember granted handles so that release and resize mostly hit live blocks
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready && m_tdata[12:2] != 0)
        begin
            seen_handles[seen_wr] <= m_tdata[12:2];
            seen_wr <= (seen_wr + 1) % 64;
        end
    end

    // Watchdog: count cycles with no beat on either stream channel and no APB access
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("FAIL");
            $finish;
        end
    end

    // Present one request beat and hold it until taken
    task automatic send_req(logic [1:0] op, logic [31:0] sz, logic [10:0] h);
        while (!calm && $urandom_range(0, 99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b0, h, sz, op};
        op_count[op]++;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
    endtask

    // Drop valid and let the allocator drain completely
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 60)
            return $urandom_range(1, 2048);
        if (r < 82)
            return $urandom_range(1, 32'(1) << $urandom_range(11, 20));
        if (r < 88)
            return 32'(1) << $urandom_range(10, 20);
        return $urandom;
    endfunction

    function automatic logic [10:0] pick_handle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 11'd0;
        if (r < 80)
            return seen_handles[$urandom_range(0, 63)];
        if (r < 92)
            return 11'($urandom_range(0, 1024));
        return (r < 96) ? 11'd1024 : 11'd1023;
    endfunction

    task automatic random_reqs(int n);
        int          r;
        logic [1:0]  op;
        for (int i = 0; i < n; i++)
        begin
            calm = (i >= n / 2 && i < n / 2 + 60);
            r = $urandom_range(0, 99);
            if (r < 45)
                op = OP_ALLOC;
            else if (r < 72)
                op = OP_RELEASE;
            else if (r < 95)
                op = OP_RESIZE;
            else
                op = 2'd3;
            send_req(op, pick_size(), pick_handle());
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        idle_cycles = 0;
        seen_wr = 0;
        foreach (seen_handles[i])
            seen_handles[i] = 11'(i % 8 + 1);
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No blocks yet, so the heap top follows the new base
        apb_write(3'd0, 32'h0000_1000);
        apb_write(3'd4, 32'hFFFF_FFFF);

        // Directed: edge sizes, every op, list reuse and the odd handles
        send_req(OP_ALLOC, 0, 0);                 // size zero reports the top
        send_req(OP_ALLOC, 100, 0);               // handle 1, bucket 0
        send_req(OP_ALLOC, 32'hFFFF_FFFF, 0);     // beyond the limit
        send_req(OP_ALLOC, 5000, 0);              // handle 2
        send_req(OP_ALLOC, 1024, 0);              // handle 3, bucket 1
        send_req(OP_RELEASE, 0, 0);               // null handle
        send_req(OP_RELEASE, 0, 11'd1024);        // never created
        send_req(OP_RELEASE, 0, 11'd1);
        send_req(OP_RELEASE, 0, 11'd1);           // double release
        send_req(OP_ALLOC, 50, 0);                // reuse from the free list
        send_req(OP_RESIZE, 200, 0);              // null resize allocates
        send_req(OP_RESIZE, 200, 11'd1000);       // invalid
        send_req(OP_RESIZE, 4000, 11'd2);         // big enough: keep
        send_req(OP_RESIZE, 9000, 11'd2);         // grow: move and release
        send_req(OP_RESIZE, 0, 11'd3);            // resize to zero releases
        send_req(2'd3, 32'hFFFF_FFFF, 11'd2047);  // unknown op
        send_req(OP_ALLOC, 32'h8000_0000, 0);
        send_req(OP_RESIZE, 32'hF000_0000, 11'd1); // grow fails, keep old
        send_req(OP_ALLOC, 3000, 0);              // bucket 2 list empty: carve at the top
        send_req(OP_ALLOC, 32'h7FFF_FFFF, 0);
        random_reqs(600);

        // Limit at zero: carving fails, so only free-list hits grant new blocks
        drain();
        apb_write(3'd4, 32'h0000_0000);
        random_reqs(80);

        drain();
        apb_write(3'd0, 32'hFFFF_FFFF);
        apb_write(3'd4, 32'hFFFF_FFFF);
        random_reqs(450);

        drain();
        apb_write(3'd0, 32'h0000_0000);
        apb_write(3'd4, 32'h8000_0000);
        random_reqs(450);

        drain();
        repeat (30) @(posedge clk);
        $display("Covered %0d allocate, %0d release, %0d resize, %0d unknown-op beats",
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("over four heap settings; %0d result beats compared", checked);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
